// ----- hdl/cmi_pkg.sv -----
// ----------------------------------------------------------------------------
// cmi_pkg: shared types and constants of the colour map interpolator
// Table geometry, channel formats and the structs passed between stages.
// ----------------------------------------------------------------------------
package cmi_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int ENTRY_W     = 8;
	localparam int CHAN_W      = 17;
	localparam int FRAC_W      = 16;
	localparam int POS_W       = 32;
	localparam int BYTE_W      = 8;
	localparam int NUM_CH      = 3;

	// channel order inside packed colour vectors
	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	localparam logic [CHAN_W-1:0] ONE_Q16  = CHAN_W'(65536);
	localparam logic [BYTE_W-1:0] BYTE_MAX = BYTE_W'(255);
	localparam logic [BYTE_W-1:0] ALPHA    = BYTE_W'(8'hFF);

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_MAP  = 1'b1
	} cmd_t;

	typedef logic [NUM_CH-1:0][CHAN_W-1:0] rgb_t;
	typedef logic [NUM_CH-1:0][BYTE_W-1:0] color_t;

	// index stage to table stage
	typedef struct packed {
		logic                valid;
		cmd_t                cmd;
		logic                wr_en;
		logic [IDX_W-1:0]    wr_addr;
		rgb_t                wr_data;
		logic [IDX_W-1:0]    idx;
		logic [IDX_W-1:0]    up;
		logic [FRAC_W-1:0]   frac;
	} lookup_t;

	// table stage to blend stages
	typedef struct packed {
		logic                valid;
		logic [FRAC_W-1:0]   frac;
		rgb_t                lo;
		rgb_t                hi;
	} table_rd_t;

endpackage

// ----- hdl/cmi_index.sv -----
// ----------------------------------------------------------------------------
// cmi_index: position to table index and fraction
// Clamps the position, squares it, scales by the table length minus one and
// splits the result into lower index, upper index and 16-bit fraction.
// ----------------------------------------------------------------------------
module cmi_index (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic                                in_valid,
	input  cmi_pkg::cmd_t                       cmd,
	input  logic [cmi_pkg::ENTRY_W-1:0]         entry_index,
	input  cmi_pkg::rgb_t                       wr_data,
	input  logic signed [cmi_pkg::POS_W-1:0]    position,
	output cmi_pkg::lookup_t                    lk_s3
);

	localparam int SQ_W = 2 * cmi_pkg::FRAC_W + 1;
	localparam int V_W  = SQ_W + cmi_pkg::IDX_W;

	logic [cmi_pkg::CHAN_W-1:0]   pos_clamped;
	logic                         wr_en;
	logic [2*cmi_pkg::CHAN_W-1:0] sq_full;
	logic [V_W-1:0]               v;
	logic [cmi_pkg::IDX_W-1:0]    idx;
	logic [cmi_pkg::FRAC_W-1:0]   frac;

	logic                         valid_s1, valid_s2, valid_s3;
	cmi_pkg::cmd_t                cmd_s1, cmd_s2, cmd_s3;
	logic                         wr_en_s1, wr_en_s2, wr_en_s3;
	logic [cmi_pkg::IDX_W-1:0]    addr_s1, addr_s2, addr_s3;
	cmi_pkg::rgb_t                data_s1, data_s2, data_s3;
	logic [cmi_pkg::CHAN_W-1:0]   pos_s1;
	logic [SQ_W-1:0]              sq_s2;
	logic [cmi_pkg::IDX_W-1:0]    idx_s3, up_s3;
	logic [cmi_pkg::FRAC_W-1:0]   frac_s3;

	always_comb begin
		if (position[cmi_pkg::POS_W-1]) begin
			pos_clamped = '0;
		end else if (position[cmi_pkg::POS_W-2:0] > (cmi_pkg::POS_W-1)'(cmi_pkg::ONE_Q16)) begin
			pos_clamped = cmi_pkg::ONE_Q16;
		end else begin
			pos_clamped = position[cmi_pkg::CHAN_W-1:0];
		end
	end

	assign wr_en   = (32'(entry_index) < cmi_pkg::TABLE_DEPTH);
	assign sq_full = pos_s1 * pos_s1;
	assign v       = V_W'(sq_s2) * V_W'(cmi_pkg::TABLE_DEPTH - 1);
	assign idx     = v[2*cmi_pkg::FRAC_W +: cmi_pkg::IDX_W];
	assign frac    = v[cmi_pkg::FRAC_W +: cmi_pkg::FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s1   <= cmd;
			wr_en_s1 <= wr_en;
			addr_s1  <= cmi_pkg::IDX_W'(entry_index);
			data_s1  <= wr_data;
			pos_s1   <= pos_clamped;

			cmd_s2   <= cmd_s1;
			wr_en_s2 <= wr_en_s1;
			addr_s2  <= addr_s1;
			data_s2  <= data_s1;
			sq_s2    <= sq_full[SQ_W-1:0];

			cmd_s3   <= cmd_s2;
			wr_en_s3 <= wr_en_s2;
			addr_s3  <= addr_s2;
			data_s3  <= data_s2;
			idx_s3   <= idx;
			frac_s3  <= frac;
			// an exact index needs no upper neighbour; the last entry has none
			if (frac != '0 && idx != cmi_pkg::IDX_W'(cmi_pkg::TABLE_DEPTH - 1)) begin
				up_s3 <= idx + 1'b1;
			end else begin
				up_s3 <= idx;
			end
		end
	end

	always_comb begin
		lk_s3.valid   = valid_s3;
		lk_s3.cmd     = cmd_s3;
		lk_s3.wr_en   = wr_en_s3;
		lk_s3.wr_addr = addr_s3;
		lk_s3.wr_data = data_s3;
		lk_s3.idx     = idx_s3;
		lk_s3.up      = up_s3;
		lk_s3.frac    = frac_s3;
	end

endmodule

// ----- hdl/cmi_table.sv -----
// ----------------------------------------------------------------------------
// cmi_table: colour table storage
// One write port for load transfers, two registered read ports for the
// lower and upper neighbours of a map transfer.
// ----------------------------------------------------------------------------
module cmi_table (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  cmi_pkg::lookup_t     lk,
	output cmi_pkg::table_rd_t   rd_s4
);

	cmi_pkg::rgb_t              mem [cmi_pkg::TABLE_DEPTH];
	logic                       valid_s4;
	logic [cmi_pkg::FRAC_W-1:0] frac_s4;
	cmi_pkg::rgb_t              lo_s4, hi_s4;

	// loads and maps meet the table at the same stage, so order is kept
	always_ff @(posedge clk) begin
		if (advance && lk.valid && lk.cmd == cmi_pkg::CMD_LOAD && lk.wr_en) begin
			mem[lk.wr_addr] <= lk.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lo_s4   <= mem[lk.idx];
			hi_s4   <= mem[lk.up];
			frac_s4 <= lk.frac;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (advance) begin
			// drop load transfers here: they give no result
			valid_s4 <= lk.valid && lk.cmd == cmi_pkg::CMD_MAP;
		end
	end

	always_comb begin
		rd_s4.valid = valid_s4;
		rd_s4.frac  = frac_s4;
		rd_s4.lo    = lo_s4;
		rd_s4.hi    = hi_s4;
	end

endmodule

// ----- hdl/cmi_blend.sv -----
// ----------------------------------------------------------------------------
// cmi_blend: linear blend and byte conversion
// Weights both neighbours by the fraction, sums, scales by 255 with
// truncation and saturates each channel to a byte.
// ----------------------------------------------------------------------------
module cmi_blend (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  cmi_pkg::table_rd_t   rd,
	output logic                 valid_s7,
	output cmi_pkg::color_t      color_s7
);

	localparam int PROD_W = 2 * cmi_pkg::CHAN_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int SCL_W  = SUM_W + cmi_pkg::BYTE_W;
	localparam int B_W    = SCL_W - 2 * cmi_pkg::FRAC_W;

	logic [cmi_pkg::CHAN_W-1:0]                    w_lo;
	logic [cmi_pkg::CHAN_W-1:0]                    w_hi;
	logic [cmi_pkg::NUM_CH-1:0][SCL_W-1:0]         scaled;
	logic [cmi_pkg::NUM_CH-1:0][B_W-1:0]           b;

	logic                                          valid_s5, valid_s6;
	logic [cmi_pkg::NUM_CH-1:0][PROD_W-1:0]        lo_p_s5, hi_p_s5;
	logic [cmi_pkg::NUM_CH-1:0][SUM_W-1:0]         sum_s6;

	assign w_hi = cmi_pkg::CHAN_W'(rd.frac);
	assign w_lo = cmi_pkg::ONE_Q16 - w_hi;

	always_comb begin
		for (int i = 0; i < cmi_pkg::NUM_CH; i++) begin
			// 255 * c as (c << 8) - c
			scaled[i] = {sum_s6[i], {cmi_pkg::BYTE_W{1'b0}}} - SCL_W'(sum_s6[i]);
			b[i]      = scaled[i][SCL_W-1 -: B_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (advance) begin
			valid_s5 <= rd.valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < cmi_pkg::NUM_CH; i++) begin
				lo_p_s5[i] <= rd.lo[i] * w_lo;
				hi_p_s5[i] <= rd.hi[i] * w_hi;
				sum_s6[i]  <= SUM_W'(lo_p_s5[i]) + SUM_W'(hi_p_s5[i]);
				if (b[i] > B_W'(cmi_pkg::BYTE_MAX)) begin
					color_s7[i] <= cmi_pkg::BYTE_MAX;
				end else begin
					color_s7[i] <= b[i][cmi_pkg::BYTE_W-1:0];
				end
			end
		end
	end

endmodule

// ----- hdl/colormap_interpolator.sv -----
// ----------------------------------------------------------------------------
// colormap_interpolator: colour table lookup with linear interpolation
// Maps a Q16.16 position to an ARGB colour through a loaded table.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): command 0 loads red_in, green_in and
// blue_in into entry entry_index and gives no result; command 1 maps
// position and gives exactly one result on the output channel.
// Output channel (out_valid/out_ready): red, green, blue and argb_word
// (alpha 0xFF in the top byte) of one map transfer.
// Pipeline: seven register stages (clamp, square, index scaling, table read,
// weighting, sum, byte scaling); out_valid is the valid bit of the last stage.
// Throughput: one transfer per cycle while the receiver does not stall; every stage is a register stage and
// the table has one write and two read ports, so loads and maps mix freely.
// A load followed directly by a map of the same entry sees the new data.
// When the receiver stalls, the whole pipeline holds and in_ready falls;
// in_ready stays high while the output register is empty or being taken.
// Reset clears all valid bits; table contents stay undefined until loaded,
// and no map may read an entry that was never loaded.
// ----------------------------------------------------------------------------
module colormap_interpolator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic [cmi_pkg::ENTRY_W-1:0]         entry_index,
	input  logic [cmi_pkg::CHAN_W-1:0]          red_in,
	input  logic [cmi_pkg::CHAN_W-1:0]          green_in,
	input  logic [cmi_pkg::CHAN_W-1:0]          blue_in,
	input  logic signed [cmi_pkg::POS_W-1:0]    position,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [cmi_pkg::BYTE_W-1:0]          red,
	output logic [cmi_pkg::BYTE_W-1:0]          green,
	output logic [cmi_pkg::BYTE_W-1:0]          blue,
	output logic [4*cmi_pkg::BYTE_W-1:0]        argb_word
);

	logic                 advance;
	cmi_pkg::rgb_t        wr_data;
	cmi_pkg::lookup_t     lk_s3;
	cmi_pkg::table_rd_t   rd_s4;
	cmi_pkg::color_t      color_s7;

	// advance everything unless a finished result is being held
	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	always_comb begin
		wr_data                   = '0;
		wr_data[cmi_pkg::CH_RED]   = red_in;
		wr_data[cmi_pkg::CH_GREEN] = green_in;
		wr_data[cmi_pkg::CH_BLUE]  = blue_in;
	end

	cmi_index u_index (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.in_valid    (in_valid),
		.cmd         (cmi_pkg::cmd_t'(command)),
		.entry_index (entry_index),
		.wr_data     (wr_data),
		.position    (position),
		.lk_s3       (lk_s3)
	);

	cmi_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.lk      (lk_s3),
		.rd_s4   (rd_s4)
	);

	cmi_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.rd       (rd_s4),
		.valid_s7 (out_valid),
		.color_s7 (color_s7)
	);

	assign red       = color_s7[cmi_pkg::CH_RED];
	assign green     = color_s7[cmi_pkg::CH_GREEN];
	assign blue      = color_s7[cmi_pkg::CH_BLUE];
	assign argb_word = {cmi_pkg::ALPHA, color_s7[cmi_pkg::CH_RED],
		color_s7[cmi_pkg::CH_GREEN], color_s7[cmi_pkg::CH_BLUE]};

endmodule
